### src/rrsp_pkg.sv
// ----------------------------------------------------------------------------
// rrsp_pkg
// Shared types and constants of the reply stream parser.
// ----------------------------------------------------------------------------
package rrsp_pkg;

   localparam int MAX_DEPTH_DEF = 8;
   localparam int LVL_W         = 4;
   localparam int QDEPTH        = 4;
   localparam logic [31:0] MAX_BULK_RST = 32'd536870912;

   // byte classes found by the front end
   typedef enum logic [3:0] {
      CLS_MINUS, CLS_PLUS, CLS_COLON, CLS_STAR, CLS_DOLLAR,
      CLS_CR, CLS_LF, CLS_SPACE, CLS_DIGIT, CLS_OTHER
   } cls_type;

   typedef struct packed {
      logic [7:0] data;
      cls_type    cls;
      logic [3:0] digit;
   } tok_type;

   // event kinds
   localparam logic [3:0] EV_INT    = 4'd0;
   localparam logic [3:0] EV_SIMPLE = 4'd1;
   localparam logic [3:0] EV_BULK   = 4'd2;
   localparam logic [3:0] EV_ETYPE  = 4'd3;
   localparam logic [3:0] EV_EMSG   = 4'd4;
   localparam logic [3:0] EV_ARR    = 4'd5;
   localparam logic [3:0] EV_NULL   = 4'd6;
   localparam logic [3:0] EV_BHDR   = 4'd7;
   localparam logic [3:0] EV_PERR   = 4'd8;

   // header kinds
   localparam logic [2:0] H_INT    = 3'd0;
   localparam logic [2:0] H_ARR    = 3'd1;
   localparam logic [2:0] H_BULK   = 3'd2;
   localparam logic [2:0] H_SIMPLE = 3'd3;
   localparam logic [2:0] H_ERR    = 3'd4;

   // largest accumulator that can still take one more digit
   localparam logic [63:0] ACC_LIMIT = 64'd922337203685477580;

   typedef struct packed {
      logic [3:0]        kind;
      logic [7:0]        data;
      logic [63:0]       value;
      logic [LVL_W-1:0]  depth;
      logic              done;
      logic [LVL_W-1:0]  closed;
      logic              rdone;
   } evt_type;

   function automatic tok_type classify(input logic [7:0] b);
      tok_type t;
      t.data  = b;
      t.digit = b[3:0];
      if (b >= 8'h30 && b <= 8'h39) t.cls = CLS_DIGIT;
      else if (b == 8'h2D) t.cls = CLS_MINUS;
      else if (b == 8'h2B) t.cls = CLS_PLUS;
      else if (b == 8'h3A) t.cls = CLS_COLON;
      else if (b == 8'h2A) t.cls = CLS_STAR;
      else if (b == 8'h24) t.cls = CLS_DOLLAR;
      else if (b == 8'h0D) t.cls = CLS_CR;
      else if (b == 8'h0A) t.cls = CLS_LF;
      else if (b == 8'h20) t.cls = CLS_SPACE;
      else t.cls = CLS_OTHER;
      return t;
   endfunction

endpackage

### src/resp_reply_stream_parser.sv
// ----------------------------------------------------------------------------
// resp_reply_stream_parser
// Byte-serial reply stream parser with nested array tracking.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  req     | in  | req_tvalid/tready    | tdata[7:0] rx_byte
//  rsp     | out | rsp_tvalid/tready    | tuser event_kind, tdata event fields
//  csr     | in  | csr_valid/csr_ready  | csr_data max_bulk_length
//
//  One byte per cycle unless the output stalls; each byte is classified as it
//  enters a four-word queue and takes one parser step into the output register.
//  Reset clears the parser state and loads the default bulk length limit.
//  Either side may stall; the queue and the output register decouple them.
module resp_reply_stream_parser #(
   parameter int MAX_DEPTH = rrsp_pkg::MAX_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // data_byte[7:0], number_value[71:8], nest_depth[75:72], element_done[76],
   // levels_closed[80:77], reply_done[81], zero fill
   output logic [87:0] rsp_tdata,
   output logic [3:0]  rsp_tuser,   // event_kind
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data
);
   logic              q_valid, q_ready;
   rrsp_pkg::tok_type q_tok;
   rrsp_pkg::evt_type ev;

   assign csr_ready = 1'b1;

   rrsp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_byte  (req_tdata),
      .q_valid  (q_valid),
      .q_ready  (q_ready),
      .q_tok    (q_tok)
   );

   rrsp_back #(.MAX_DEPTH(MAX_DEPTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_tok     (q_tok),
      .cfg_valid (csr_valid),
      .cfg_data  (csr_data),
      .ev_valid  (rsp_tvalid),
      .ev_ready  (rsp_tready),
      .ev        (ev)
   );

   // word packing
   assign rsp_tuser = ev.kind;
   assign rsp_tdata = {6'd0, ev.rdone, ev.closed, ev.done, ev.depth, ev.value, ev.data};

endmodule

### src/rrsp_front.sv
// ----------------------------------------------------------------------------
// rrsp_front
// Takes input words, classifies each byte and queues it for the parser.
// ----------------------------------------------------------------------------
module rrsp_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [7:0]       in_byte,
   output logic             q_valid,
   input  logic             q_ready,
   output rrsp_pkg::tok_type q_tok
);
   localparam int PW = $clog2(rrsp_pkg::QDEPTH);

   rrsp_pkg::tok_type mem [rrsp_pkg::QDEPTH];
   logic [PW-1:0] wr_ff, rd_ff;
   logic [PW:0]   cnt_ff;
   logic          push, pop;

   assign in_ready = cnt_ff != (PW+1)'(rrsp_pkg::QDEPTH);
   assign q_valid  = cnt_ff != '0;
   assign push     = in_valid && in_ready;
   assign pop      = q_valid && q_ready;
   assign q_tok    = mem[rd_ff];

   // queue storage
   always_ff @(posedge clock) begin
      if (push) mem[wr_ff] <= rrsp_pkg::classify(in_byte);
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop)  rd_ff <= rd_ff + 1'b1;
         if (push && !pop) cnt_ff <= cnt_ff + 1'b1;
         else if (pop && !push) cnt_ff <= cnt_ff - 1'b1;
      end
   end

endmodule

### src/rrsp_back.sv
// ----------------------------------------------------------------------------
// rrsp_back
// Parser state machine, array count stack and registered event output.
// ----------------------------------------------------------------------------
module rrsp_back #(
   parameter int MAX_DEPTH = rrsp_pkg::MAX_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   output logic              q_ready,
   input  rrsp_pkg::tok_type q_tok,
   input  logic              cfg_valid,
   input  logic [31:0]       cfg_data,
   output logic              ev_valid,
   input  logic              ev_ready,
   output rrsp_pkg::evt_type ev
);
   localparam int LW = rrsp_pkg::LVL_W;
   localparam int IW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

   typedef enum logic [3:0] {
      M_TYPE, M_NSTART, M_NSIGN, M_NDIG, M_NBAD, M_NLF, M_NBADLF,
      M_SIMPLE, M_ETYPE, M_ESKIP, M_EMSG, M_BDATA, M_BCR, M_SLF
   } mode_type;

   mode_type mode_ff, mode_in;
   logic [2:0]  hkind_ff, hkind_in;
   logic [63:0] acc_ff, acc_in;
   logic        neg_ff, neg_in;
   logic [31:0] bleft_ff, bleft_in;
   logic [LW-1:0] lvl_ff, lvl_in;
   logic [31:0] max_bulk_ff;
   logic [31:0] cnt_mem [MAX_DEPTH];
   logic [MAX_DEPTH-1:0] le1_ff;
   logic        ev_valid_ff;
   rrsp_pkg::evt_type ev_ff, ev_in;

   logic proc, emit, do_perr, do_comp, do_push;
   logic [3:0]  comp_kind;
   logic [63:0] comp_val, hval, acc_x10, thr;
   logic [LW-1:0] closed, tgt;
   logic        rdone, run;
   logic [31:0] tgt_cnt;
   rrsp_pkg::tok_type t;

   assign t        = q_tok;
   assign q_ready  = !ev_valid_ff || ev_ready;
   assign proc     = q_valid && q_ready;
   assign ev_valid = ev_valid_ff;
   assign ev       = ev_ff;

   // levels that finish with the current element, from the top down
   always_comb begin
      run    = 1'b1;
      closed = '0;
      for (int k = 0; k < MAX_DEPTH; k++) begin
         if (run && (LW'(k) < lvl_ff) && le1_ff[IW'(lvl_ff - LW'(1) - LW'(k))])
            closed = closed + 1'b1;
         else
            run = 1'b0;
      end
      rdone   = closed == lvl_ff;
      tgt     = lvl_ff - LW'(1) - closed;
      tgt_cnt = cnt_mem[tgt[IW-1:0]];
   end

   // parse step
   always_comb begin
      mode_in  = mode_ff;
      hkind_in = hkind_ff;
      acc_in   = acc_ff;
      neg_in   = neg_ff;
      bleft_in = bleft_ff;
      emit     = 1'b0;
      do_perr  = 1'b0;
      do_comp  = 1'b0;
      do_push  = 1'b0;
      comp_kind = rrsp_pkg::EV_INT;
      comp_val  = '0;
      ev_in     = '0;
      ev_in.depth = lvl_ff;
      hval    = neg_ff ? (64'd0 - acc_ff) : acc_ff;
      acc_x10 = (acc_ff << 3) + (acc_ff << 1) + {60'd0, t.digit};
      thr     = rrsp_pkg::ACC_LIMIT -
                64'(t.digit > (neg_ff ? 4'd8 : 4'd7));
      unique case (mode_ff)
         M_TYPE: begin
            acc_in = '0;
            neg_in = 1'b0;
            unique case (t.cls)
               rrsp_pkg::CLS_MINUS: begin
                  hkind_in = rrsp_pkg::H_ERR; mode_in = M_ETYPE;
               end
               rrsp_pkg::CLS_PLUS: begin
                  hkind_in = rrsp_pkg::H_SIMPLE; mode_in = M_SIMPLE;
               end
               rrsp_pkg::CLS_COLON: begin
                  hkind_in = rrsp_pkg::H_INT; mode_in = M_NSTART;
               end
               rrsp_pkg::CLS_STAR: begin
                  hkind_in = rrsp_pkg::H_ARR; mode_in = M_NSTART;
               end
               rrsp_pkg::CLS_DOLLAR: begin
                  hkind_in = rrsp_pkg::H_BULK; mode_in = M_NSTART;
               end
               default: do_perr = 1'b1;
            endcase
         end
         M_NSTART, M_NSIGN, M_NDIG: begin
            if (t.cls == rrsp_pkg::CLS_DIGIT) begin
               if (acc_ff > thr) mode_in = M_NBAD;
               else begin
                  acc_in  = acc_x10;
                  mode_in = M_NDIG;
               end
            end else if (mode_ff == M_NSTART && t.cls == rrsp_pkg::CLS_MINUS) begin
               neg_in  = 1'b1;
               mode_in = M_NSIGN;
            end else if (t.cls == rrsp_pkg::CLS_CR)
               mode_in = (mode_ff == M_NDIG) ? M_NLF : M_NBADLF;
            else
               mode_in = M_NBAD;
         end
         M_NBAD: begin
            if (t.cls == rrsp_pkg::CLS_CR) mode_in = M_NBADLF;
         end
         M_NBADLF: do_perr = 1'b1;
         M_NLF: begin
            if (t.cls != rrsp_pkg::CLS_LF) do_perr = 1'b1;
            else if (hkind_ff == rrsp_pkg::H_INT) begin
               do_comp = 1'b1; comp_kind = rrsp_pkg::EV_INT; comp_val = hval;
            end else if (neg_ff && acc_ff != '0) begin
               if (acc_ff == 64'd1) begin
                  do_comp = 1'b1; comp_kind = rrsp_pkg::EV_NULL; comp_val = '1;
               end else do_perr = 1'b1;
            end else if (hkind_ff == rrsp_pkg::H_ARR) begin
               if (acc_ff == '0) begin
                  do_comp = 1'b1; comp_kind = rrsp_pkg::EV_ARR;
               end else if (acc_ff[63:32] != '0 || lvl_ff >= LW'(MAX_DEPTH))
                  do_perr = 1'b1;
               else begin
                  do_push     = 1'b1;
                  mode_in     = M_TYPE;
                  emit        = 1'b1;
                  ev_in.kind  = rrsp_pkg::EV_ARR;
                  ev_in.value = acc_ff;
               end
            end else if (acc_ff > {32'd0, max_bulk_ff})
               do_perr = 1'b1;
            else begin
               bleft_in    = acc_ff[31:0];
               mode_in     = (acc_ff != '0) ? M_BDATA : M_BCR;
               emit        = 1'b1;
               ev_in.kind  = rrsp_pkg::EV_BHDR;
               ev_in.value = acc_ff;
            end
         end
         M_SIMPLE: begin
            if (t.cls == rrsp_pkg::CLS_CR) mode_in = M_SLF;
            else begin
               emit = 1'b1; ev_in.kind = rrsp_pkg::EV_SIMPLE; ev_in.data = t.data;
            end
         end
         M_ETYPE: begin
            if (t.cls == rrsp_pkg::CLS_CR) mode_in = M_SLF;
            else if (t.cls == rrsp_pkg::CLS_SPACE) mode_in = M_ESKIP;
            else begin
               emit = 1'b1; ev_in.kind = rrsp_pkg::EV_ETYPE; ev_in.data = t.data;
            end
         end
         M_ESKIP, M_EMSG: begin
            if (t.cls == rrsp_pkg::CLS_CR) mode_in = M_SLF;
            else if (!(t.cls == rrsp_pkg::CLS_SPACE && mode_ff == M_ESKIP)) begin
               mode_in = M_EMSG;
               emit = 1'b1; ev_in.kind = rrsp_pkg::EV_EMSG; ev_in.data = t.data;
            end
         end
         M_BDATA: begin
            bleft_in = (bleft_ff != '0) ? bleft_ff - 32'd1 : '0;
            if (bleft_in == '0) mode_in = M_BCR;
            emit = 1'b1; ev_in.kind = rrsp_pkg::EV_BULK; ev_in.data = t.data;
         end
         M_BCR: begin
            if (t.cls != rrsp_pkg::CLS_CR) do_perr = 1'b1;
            else mode_in = M_SLF;
         end
         M_SLF: begin
            if (t.cls != rrsp_pkg::CLS_LF) do_perr = 1'b1;
            else begin
               do_comp = 1'b1;
               if (hkind_ff == rrsp_pkg::H_BULK) comp_kind = rrsp_pkg::EV_BULK;
               else if (hkind_ff == rrsp_pkg::H_ERR) comp_kind = rrsp_pkg::EV_EMSG;
               else comp_kind = rrsp_pkg::EV_SIMPLE;
            end
         end
         default: do_perr = 1'b1;
      endcase
      // stack level update and completion / error events
      lvl_in = lvl_ff;
      if (do_push) lvl_in = lvl_ff + LW'(1);
      if (do_comp) begin
         mode_in      = M_TYPE;
         lvl_in       = lvl_ff - closed;
         emit         = 1'b1;
         ev_in.kind   = comp_kind;
         ev_in.value  = comp_val;
         ev_in.done   = 1'b1;
         ev_in.closed = closed;
         ev_in.rdone  = rdone;
      end
      if (do_perr) begin
         mode_in    = M_TYPE;
         lvl_in     = '0;
         emit       = 1'b1;
         ev_in      = '0;
         ev_in.kind = rrsp_pkg::EV_PERR;
         ev_in.depth = lvl_ff;
      end
   end

   // count stack: push writes the new top, completion decrements one entry
   always_ff @(posedge clock) begin
      if (proc && do_push) begin
         cnt_mem[lvl_ff[IW-1:0]] <= acc_ff[31:0];
         le1_ff[lvl_ff[IW-1:0]]  <= acc_ff == 64'd1;
      end else if (proc && do_comp && !rdone) begin
         cnt_mem[tgt[IW-1:0]] <= tgt_cnt - 32'd1;
         le1_ff[tgt[IW-1:0]]  <= tgt_cnt == 32'd2;
      end
   end

   // parser state and output word
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= M_TYPE;
         hkind_ff    <= rrsp_pkg::H_INT;
         acc_ff      <= '0;
         neg_ff      <= 1'b0;
         bleft_ff    <= '0;
         lvl_ff      <= '0;
         max_bulk_ff <= rrsp_pkg::MAX_BULK_RST;
         ev_valid_ff <= 1'b0;
      end else begin
         if (cfg_valid) max_bulk_ff <= cfg_data;
         if (proc) begin
            mode_ff  <= mode_in;
            hkind_ff <= hkind_in;
            acc_ff   <= acc_in;
            neg_ff   <= neg_in;
            bleft_ff <= bleft_in;
            lvl_ff   <= lvl_in;
         end
         if (proc && emit) ev_valid_ff <= 1'b1;
         else if (ev_ready) ev_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (proc && emit) ev_ff <= ev_in;
   end

   // checks
   a_lvl_bound: assert property (@(posedge clock) disable iff (reset)
      lvl_ff <= LW'(MAX_DEPTH))
      else $error("stack level above maximum depth");

   a_perr_drop: assert property (@(posedge clock) disable iff (reset)
      (proc && do_perr) |=> (lvl_ff == '0 && mode_ff == M_TYPE))
      else $error("open arrays kept after protocol error");

   a_rdone_all: assert property (@(posedge clock) disable iff (reset)
      (ev_valid_ff && ev_ff.rdone) |-> (ev_ff.closed == ev_ff.depth && ev_ff.done))
      else $error("reply done without closing every level");

endmodule
